// ----- design/csc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC sine/cosine package
// Shared widths, the micro-rotation vector type and the arctangent table.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int MAX_ITERATIONS = 14;
    localparam int FRACTION_BITS  = 13;
    localparam int ANGLE_W        = 15;
    localparam int OUT_W          = 16;
    // Internal datapath width leaves headroom above the 16-bit results.
    localparam int VEC_W          = 18;
    localparam int SHIFT_W        = 4;
    localparam int CFG_W          = 4;

    // Index of the iteration count register in the register file.
    localparam logic REG_ITERATION_COUNT = 1'b0;

    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [CFG_W-1:0]   count_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec_t;

    // atan(2^-i) in Q13 radians.
    function automatic logic signed [VEC_W-1:0] atan_value(input shift_t idx);
        logic signed [VEC_W-1:0] v;
        begin
            case (idx)
                4'd0:    v = 18'sd6433;
                4'd1:    v = 18'sd3797;
                4'd2:    v = 18'sd2005;
                4'd3:    v = 18'sd1018;
                4'd4:    v = 18'sd510;
                4'd5:    v = 18'sd254;
                4'd6:    v = 18'sd127;
                4'd7:    v = 18'sd62;
                4'd8:    v = 18'sd31;
                4'd9:    v = 18'sd15;
                4'd10:   v = 18'sd7;
                4'd11:   v = 18'sd3;
                4'd12:   v = 18'sd1;
                default: v = 18'sd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/csc_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC configuration registers
// Register file behind the configuration port; holds the iteration count and
// presents it saturated to the table length.
// ----------------------------------------------------------------------------
module csc_cfg (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output csc_pkg::count_t            iter_n
);

    csc_pkg::count_t count_reg;
    csc_pkg::count_t count_next;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == csc_pkg::REG_ITERATION_COUNT);

    always_comb begin
        count_next = count_reg;
        if (wr_en) begin
            count_next = pwdata[csc_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= csc_pkg::count_t'(csc_pkg::MAX_ITERATIONS);
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == csc_pkg::REG_ITERATION_COUNT) begin
            prdata = {{(32-csc_pkg::CFG_W){1'b0}}, count_reg};
        end
    end

    assign iter_n = (count_reg > csc_pkg::count_t'(csc_pkg::MAX_ITERATIONS))
                  ? csc_pkg::count_t'(csc_pkg::MAX_ITERATIONS) : count_reg;

endmodule
`default_nettype wire

// ----- design/csc_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC micro-rotation stage
// One registered rotation step with its own valid bit and ready back-pressure.
// ----------------------------------------------------------------------------
module csc_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire csc_pkg::shift_t                shift,
    input  wire logic signed [csc_pkg::VEC_W-1:0] atan,
    input  wire logic                           active,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire csc_pkg::vec_t                  in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output csc_pkg::vec_t                       out_data
);

    logic          valid_reg;
    csc_pkg::vec_t data_reg;
    csc_pkg::vec_t data_next;
    logic signed [csc_pkg::VEC_W-1:0] dx;
    logic signed [csc_pkg::VEC_W-1:0] dy;

    // A stage takes a new request whenever it is empty or its content moves on.
    assign in_ready = !valid_reg || out_ready;

    assign dx = in_data.y >>> shift;
    assign dy = in_data.x >>> shift;

    always_comb begin
        data_next = in_data;
        if (active) begin
            // A residual of exactly zero rotates in the negative direction.
            if (in_data.z > 0) begin
                data_next.x = in_data.x - dx;
                data_next.y = in_data.y + dy;
                data_next.z = in_data.z - atan;
            end else begin
                data_next.x = in_data.x + dx;
                data_next.y = in_data.y - dy;
                data_next.z = in_data.z + atan;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ----- design/cordic_rotation_sin_cos_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC rotation-mode sine/cosine unit
// Rotates (8192, 0) by the requested angle and returns x, y and the residual,
// still scaled by the CORDIC gain.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_        in         angle, Q13 radians
//  m_        out        cosine_scaled, sine_scaled, residual_angle
//  APB       in/out     iteration_count at address 0
//
// One register stage per micro-rotation of the table; a request is accepted per
// cycle unless an m_ stall fills all stages. Stages past the iteration count pass
// the vector through unchanged. Each stage has its own valid bit, so a stall
// on m_ only backs up as far as the first empty stage, and bubbles are filled
// while a result waits. Reset clears the valid bits and sets the count to 14.
// ----------------------------------------------------------------------------
module cordic_rotation_sin_cos_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [14:0] angle, [15] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [15:0] cosine_scaled, [31:16] sine_scaled,
                                        // [47:32] residual_angle
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int N = csc_pkg::MAX_ITERATIONS;

    csc_pkg::count_t iter_n;
    logic            valid_w [N+1];
    logic            ready_w [N+1];
    csc_pkg::vec_t   data_w  [N+1];

    csc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .iter_n  (iter_n)
    );

    assign valid_w[0]  = s_tvalid;
    assign s_tready    = ready_w[0];
    assign data_w[0].x = csc_pkg::VEC_W'(1 << csc_pkg::FRACTION_BITS);
    assign data_w[0].y = '0;
    assign data_w[0].z = {{(csc_pkg::VEC_W-csc_pkg::ANGLE_W){s_tdata[csc_pkg::ANGLE_W-1]}},
                          s_tdata[csc_pkg::ANGLE_W-1:0]};

    for (genvar g = 0; g < N; g++) begin : g_stage
        csc_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (csc_pkg::shift_t'(g)),
            .atan      (csc_pkg::atan_value(csc_pkg::shift_t'(g))),
            .active    (csc_pkg::count_t'(g) < iter_n),
            .in_valid  (valid_w[g]),
            .in_ready  (ready_w[g]),
            .in_data   (data_w[g]),
            .out_valid (valid_w[g+1]),
            .out_ready (ready_w[g+1]),
            .out_data  (data_w[g+1])
        );
    end

    assign ready_w[N] = m_tready;
    assign m_tvalid   = valid_w[N];
    assign m_tdata    = {data_w[N].z[csc_pkg::OUT_W-1:0],
                         data_w[N].y[csc_pkg::OUT_W-1:0],
                         data_w[N].x[csc_pkg::OUT_W-1:0]};

endmodule
`default_nettype wire

// ----- tb/sv/tb_cordic_rotation_sin_cos_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CORDIC rotation-mode sine/cosine unit
// Streams angles into the unit and checks every x, y and residual result,
// in order, against a cycle-free rotation predictor. The iteration count
// register is set to its ends and to values between, and both stream sides idle and
// stall at random in several traffic phases.
// ----------------------------------------------------------------------------
module tb_cordic_rotation_sin_cos_unit;

    localparam int          PIPE_LATENCY  = csc_pkg::MAX_ITERATIONS;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          RANDOM_ITEMS  = 1600;
    localparam logic [2:0]  ADDR_ITERATION_COUNT = 3'd0;
    localparam logic [2:0]  ADDR_UNMAPPED        = 3'd4;

    typedef struct {
        logic signed [15:0] cosine;
        logic signed [15:0] sine;
        logic signed [15:0] residual;
    } rotation_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    csc_pkg::count_t iteration_setting;
    rotation_t   pending_rotations [$];
    rotation_t   oldest_rotation;
    int          error_count;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    cordic_rotation_sin_cos_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // atan(2^-i) in Q13 radians; the last entry rounds to zero.
    function automatic int arctangent_q13(input int step);
        case (step)
            0:       return 6433;
            1:       return 3797;
            2:       return 2005;
            3:       return 1018;
            4:       return 510;
            5:       return 254;
            6:       return 127;
            7:       return 62;
            8:       return 31;
            9:       return 15;
            10:      return 7;
            11:      return 3;
            12:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic rotation_t predict_rotation(input logic signed [14:0] angle,
                                                   input csc_pkg::count_t count);
        int        x;
        int        y;
        int        z;
        int        dx;
        int        dy;
        int        steps;
        rotation_t r;
        x = 1 << csc_pkg::FRACTION_BITS;
        y = 0;
        z = angle;
        steps = (int'(count) > csc_pkg::MAX_ITERATIONS) ? csc_pkg::MAX_ITERATIONS
                                                        : int'(count);
        for (int i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            // A residual of exactly zero turns the vector the negative way.
            if (z > 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctangent_q13(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctangent_q13(i);
            end
        end
        r.cosine   = x[15:0];
        r.sine     = y[15:0];
        r.residual = z[15:0];
        return r;
    endfunction

    function automatic logic [14:0] random_angle();
        logic [14:0] special [8];
        special = '{15'h4000, 15'h3FFF, 15'd0, 15'd1, 15'h7FFF, 15'd6433,
                    15'd12868, -15'sd12868};
        case ($urandom_range(9))
            0:       return special[$urandom_range(7)];
            1, 2:    return 15'($urandom_range(2 * 12868) - 12868);
            3:       return 15'($urandom_range(64) - 32);
            default: return 15'($urandom);
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (addr == ADDR_ITERATION_COUNT)
            iteration_setting = data[csc_pkg::CFG_W-1:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            $error("prdata: expected %0d, got %0d", want, prdata);
            error_count++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Valid stays high from one request to the next unless an idle cycle is drawn.
    task automatic send_angle(input logic [14:0] angle);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, angle};
        do @(posedge aclk); while (!s_tready);
        pending_rotations.push_back(predict_rotation(angle, iteration_setting));
    endtask

    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_rotations.size() != 0)
            @(negedge aclk);
        repeat (PIPE_LATENCY + 2) @(negedge aclk);
    endtask

    task automatic set_traffic(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    task automatic test_reset_state();
        apb_read_check(ADDR_ITERATION_COUNT, 32'd14);
    endtask

    task automatic test_angle_extremes();
        logic [14:0] angles [12];
        angles = '{15'h4000, 15'h3FFF, 15'd0, 15'd1, 15'h7FFF, 15'd6433,
                   -15'sd6433, 15'd12868, -15'sd12868, 15'd8192, 15'h5555, 15'h2AAA};
        foreach (angles[i])
            send_angle(angles[i]);
        drain_pipeline();
    endtask

    task automatic test_iteration_extremes();
        // No rotation at all: the start vector and the angle come straight back.
        apb_write(ADDR_ITERATION_COUNT, 32'd0);
        send_angle(15'h4000);
        send_angle(15'h3FFF);
        send_angle(15'h1234);
        drain_pipeline();
        // One rotation that lands the residual exactly on zero.
        apb_write(ADDR_ITERATION_COUNT, 32'd1);
        send_angle(15'd6433);
        send_angle(15'd0);
        drain_pipeline();
        // Counts above the table length act as the full table.
        apb_write(ADDR_ITERATION_COUNT, 32'd15);
        send_angle(15'h3FFF);
        send_angle(15'h4000);
        drain_pipeline();
    endtask

    task automatic test_register_map();
        apb_write(ADDR_ITERATION_COUNT, 32'd7);
        apb_write(ADDR_UNMAPPED, 32'd2);
        apb_read_check(ADDR_ITERATION_COUNT, 32'd7);
        send_angle(15'd3000);
        drain_pipeline();
        // Only the low four bits of the write data are kept.
        apb_write(ADDR_ITERATION_COUNT, 32'hFFFF_FFF3);
        apb_read_check(ADDR_ITERATION_COUNT, 32'd3);
        send_angle(15'h7F00);
        drain_pipeline();
    endtask

    task automatic test_random_sweep();
        int counts [8];
        int segment_items;
        counts = '{14, 0, 15, 1, 7, 13, -1, -1};
        segment_items = RANDOM_ITEMS / $size(counts);
        foreach (counts[seg]) begin
            apb_write(ADDR_ITERATION_COUNT,
                      counts[seg] < 0 ? 32'($urandom_range(15)) : 32'(counts[seg]));
            case (seg % 4)
                0:       set_traffic(0, 0);
                1:       set_traffic(75, 0);
                2:       set_traffic(0, 75);
                default: set_traffic(20, 20);
            endcase
            repeat (segment_items)
                send_angle(random_angle());
            drain_pipeline();
        end
    endtask

    // Result side: random back-pressure, applied at the falling edge.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = aresetn && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rotations.size() == 0) begin
                $error("unexpected result: tdata %h", m_tdata);
                error_count++;
            end else begin
                oldest_rotation = pending_rotations.pop_front();
                if ($signed(m_tdata[15:0]) !== oldest_rotation.cosine) begin
                    $error("cosine_scaled: expected %0d, got %0d",
                           oldest_rotation.cosine, $signed(m_tdata[15:0]));
                    error_count++;
                end
                if ($signed(m_tdata[31:16]) !== oldest_rotation.sine) begin
                    $error("sine_scaled: expected %0d, got %0d",
                           oldest_rotation.sine, $signed(m_tdata[31:16]));
                    error_count++;
                end
                if ($signed(m_tdata[47:32]) !== oldest_rotation.residual) begin
                    $error("residual_angle: expected %0d, got %0d",
                           oldest_rotation.residual, $signed(m_tdata[47:32]));
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any request moving on either stream or the register port counts
    // as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn           = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        iteration_setting = 4'd14;
        error_count       = 0;
        quiet_cycles      = 0;
        idle_pct          = 0;
        stall_pct         = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_angle_extremes();
        test_iteration_extremes();
        test_register_map();
        test_random_sweep();

        while (pending_rotations.size() != 0)
            @(posedge aclk);
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
